FILE: src/lts_pkg.sv
package lts_pkg;

   // field widths
   localparam int MODE_W   = 2;
   localparam int SPEED_W  = 14;
   localparam int FLAP_W   = 10;
   localparam int RATIO_W  = 9;
   localparam int HEIGHT_W = 16;
   localparam int PHASE_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK = 2'd0,
      MODE_ARM  = 2'd1,
      MODE_STOP = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REVERSE_MIN_SPEED = 3'd0,
      CSR_ARM_MAX_AIRSPEED  = 3'd1,
      CSR_ARM_MIN_FLAP      = 3'd2,
      CSR_ARM_MAX_HEIGHT    = 3'd3,
      CSR_GEAR_DOWN_VALUE   = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [SPEED_W-1:0]         RST_REVERSE_MIN_SPEED = 14'd960;
   localparam logic [SPEED_W-1:0]         RST_ARM_MAX_AIRSPEED  = 14'd2560;
   localparam logic [FLAP_W-1:0]          RST_ARM_MIN_FLAP      = 10'd288;
   localparam logic signed [HEIGHT_W-1:0] RST_ARM_MAX_HEIGHT    = 16'sd2438;
   localparam logic [RATIO_W-1:0]         RST_GEAR_DOWN_VALUE   = 9'd256;

   typedef struct packed {
      logic [SPEED_W-1:0]         reverse_min_speed;
      logic [SPEED_W-1:0]         arm_max_airspeed;
      logic [FLAP_W-1:0]          arm_min_flap;
      logic signed [HEIGHT_W-1:0] arm_max_height;
      logic [RATIO_W-1:0]         gear_down_value;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [SPEED_W-1:0]         airspeed;
      logic [FLAP_W-1:0]          flap_angle;
      logic [RATIO_W-1:0]         gear_ratio;
      logic signed [HEIGHT_W-1:0] height_above_ground;
      logic [RATIO_W-1:0]         throttle_level;
      logic                       wheels_on_ground;
   } req_item_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               throttle_down_hold;
      logic               reverse_hold;
      logic               arm_accepted;
      logic               already_armed;
      logic               speed_too_high;
      logic               flaps_too_low;
      logic               gear_not_down;
      logic               height_too_high;
   } rsp_item_type;

endpackage

FILE: src/lts_req_if.sv
interface lts_req_if;
   import lts_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [SPEED_W-1:0]         airspeed;
   logic [FLAP_W-1:0]          flap_angle;
   logic [RATIO_W-1:0]         gear_ratio;
   logic signed [HEIGHT_W-1:0] height_above_ground;
   logic [RATIO_W-1:0]         throttle_level;
   logic                       wheels_on_ground;

   modport source (
      output valid, mode, airspeed, flap_angle, gear_ratio, height_above_ground,
             throttle_level, wheels_on_ground,
      input  ready
   );
   modport sink (
      input  valid, mode, airspeed, flap_angle, gear_ratio, height_above_ground,
             throttle_level, wheels_on_ground,
      output ready
   );
endinterface

FILE: src/lts_rsp_if.sv
interface lts_rsp_if;
   import lts_pkg::*;

   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase;
   logic               throttle_down_hold;
   logic               reverse_hold;
   logic               arm_accepted;
   logic               already_armed;
   logic               speed_too_high;
   logic               flaps_too_low;
   logic               gear_not_down;
   logic               height_too_high;

   modport source (
      output valid, phase, throttle_down_hold, reverse_hold, arm_accepted,
             already_armed, speed_too_high, flaps_too_low, gear_not_down,
             height_too_high,
      input  ready
   );
   modport sink (
      input  valid, phase, throttle_down_hold, reverse_hold, arm_accepted,
             already_armed, speed_too_high, flaps_too_low, gear_not_down,
             height_too_high,
      output ready
   );
endinterface

FILE: src/lts_csr_if.sv
interface lts_csr_if;
   import lts_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/lts_csr_regs.sv
module lts_csr_regs (
   input  logic             clock,
   input  logic             reset,
   lts_csr_if.sink          csr_chan,
   output lts_pkg::cfg_type cfg
);
   import lts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_REVERSE_MIN_SPEED: cfg_in.reverse_min_speed = csr_chan.data[SPEED_W-1:0];
            CSR_ARM_MAX_AIRSPEED:  cfg_in.arm_max_airspeed  = csr_chan.data[SPEED_W-1:0];
            CSR_ARM_MIN_FLAP:      cfg_in.arm_min_flap      = csr_chan.data[FLAP_W-1:0];
            CSR_ARM_MAX_HEIGHT:    cfg_in.arm_max_height    = csr_chan.data[HEIGHT_W-1:0];
            CSR_GEAR_DOWN_VALUE:   cfg_in.gear_down_value   = csr_chan.data[RATIO_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reverse_min_speed <= RST_REVERSE_MIN_SPEED;
         cfg_ff.arm_max_airspeed  <= RST_ARM_MAX_AIRSPEED;
         cfg_ff.arm_min_flap      <= RST_ARM_MIN_FLAP;
         cfg_ff.arm_max_height    <= RST_ARM_MAX_HEIGHT;
         cfg_ff.gear_down_value   <= RST_GEAR_DOWN_VALUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/lts_seq_fsm.sv
module lts_seq_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  lts_pkg::req_item_type item,
   input  lts_pkg::cfg_type      cfg,
   output lts_pkg::rsp_item_type result
);
   import lts_pkg::*;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE         = 3'd0,
      PH_START        = 3'd1,
      PH_THR_DOWN     = 3'd2,
      PH_WAIT_IDLE    = 3'd3,
      PH_WAIT_TOUCH   = 3'd4,
      PH_REVERSE      = 3'd5,
      PH_WAIT_REV_END = 3'd6
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      stop_ff, stop_in;
   logic      thr_hold_ff, thr_hold_in;
   logic      rev_hold_ff, rev_hold_in;

   logic spd_fail, flap_fail, gear_fail, hgt_fail;
   logic above_rev_min;

   assign spd_fail      = item.airspeed > cfg.arm_max_airspeed;
   assign flap_fail     = item.flap_angle < cfg.arm_min_flap;
   assign gear_fail     = item.gear_ratio != cfg.gear_down_value;
   assign hgt_fail      = item.height_above_ground > cfg.arm_max_height;
   assign above_rev_min = item.airspeed > cfg.reverse_min_speed;

   always_comb begin
      phase_in    = phase_ff;
      stop_in     = stop_ff;
      thr_hold_in = thr_hold_ff;
      rev_hold_in = rev_hold_ff;
      result      = '0;

      case (item.mode)
         MODE_TICK: begin
            unique case (phase_ff)
               PH_IDLE: ;
               PH_START:
                  phase_in = (item.throttle_level != '0) ? PH_THR_DOWN : PH_WAIT_TOUCH;
               PH_THR_DOWN: begin
                  thr_hold_in = 1'b1;
                  phase_in    = PH_WAIT_IDLE;
               end
               PH_WAIT_IDLE: begin
                  if (stop_ff) begin
                     thr_hold_in = 1'b0;
                     rev_hold_in = 1'b0;
                     stop_in     = 1'b0;
                     phase_in    = PH_IDLE;
                  end else if (item.throttle_level == '0) begin
                     thr_hold_in = 1'b0;
                     phase_in    = PH_WAIT_TOUCH;
                  end
               end
               PH_WAIT_TOUCH: begin
                  if (stop_ff) begin
                     thr_hold_in = 1'b0;
                     rev_hold_in = 1'b0;
                     stop_in     = 1'b0;
                     phase_in    = PH_IDLE;
                  end else if (item.wheels_on_ground) begin
                     phase_in = PH_REVERSE;
                  end
               end
               PH_REVERSE: begin
                  if (above_rev_min) begin
                     rev_hold_in = 1'b1;
                     phase_in    = PH_WAIT_REV_END;
                  end else begin
                     phase_in = PH_IDLE;  // stop stays pending here
                  end
               end
               PH_WAIT_REV_END: begin
                  if (stop_ff) begin
                     thr_hold_in = 1'b0;
                     rev_hold_in = 1'b0;
                     stop_in     = 1'b0;
                     phase_in    = PH_IDLE;
                  end else if (!above_rev_min) begin
                     rev_hold_in = 1'b0;
                     phase_in    = PH_IDLE;
                  end
               end
               default: begin  // unused code: recover to idle
                  thr_hold_in = 1'b0;
                  rev_hold_in = 1'b0;
                  stop_in     = 1'b0;
                  phase_in    = PH_IDLE;
               end
            endcase
         end
         MODE_ARM: begin
            if (phase_ff == PH_IDLE) begin
               result.speed_too_high  = spd_fail;
               result.flaps_too_low   = flap_fail;
               result.gear_not_down   = gear_fail;
               result.height_too_high = hgt_fail;
               if (!(spd_fail || flap_fail || gear_fail || hgt_fail)) begin
                  stop_in             = 1'b0;
                  phase_in            = PH_START;
                  result.arm_accepted = 1'b1;
               end
            end else begin
               result.already_armed = 1'b1;
            end
         end
         MODE_STOP: begin
            if (phase_ff != PH_IDLE) stop_in = 1'b1;
         end
         default: ;  // unused mode: report state only
      endcase

      result.phase              = phase_in;
      result.throttle_down_hold = thr_hold_in;
      result.reverse_hold       = rev_hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         stop_ff     <= 1'b0;
         thr_hold_ff <= 1'b0;
         rev_hold_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         stop_ff     <= stop_in;
         thr_hold_ff <= thr_hold_in;
         rev_hold_ff <= rev_hold_in;
      end
   end

   // throttle hold lives exactly in the wait-idle phase
   a_thr_hold_phase: assert property (@(posedge clock) disable iff (reset)
      thr_hold_ff == (phase_ff == PH_WAIT_IDLE))
      else $error("throttle hold out of step with phase");

   // reverse hold lives exactly in the wait-reverse-end phase
   a_rev_hold_phase: assert property (@(posedge clock) disable iff (reset)
      rev_hold_ff == (phase_ff == PH_WAIT_REV_END))
      else $error("reverse hold out of step with phase");

   // an accepted arm always lands in the start phase
   a_arm_start: assert property (@(posedge clock) disable iff (reset)
      step && result.arm_accepted |=> phase_ff == PH_START)
      else $error("accepted arm did not start sequence");

endmodule

FILE: src/landing_thrust_sequencer.sv
// Landing thrust sequencer. One result word for every request word, in order.
// A request word passes through an input register, the sequencer logic works
// out the new phase, holds and arm flags combinationally, and the result lands
// in an output register: one word per cycle sustained while results are taken,
// with the input register and then the result register between request and
// result. The request side keeps taking words while a result waits, stalling
// only when both registers are full and the result is not taken. Configuration
// writes are taken every cycle (csr ready is tied high) and should be made
// while no request is in flight; unmapped indexes are dropped.
module landing_thrust_sequencer (
   input  logic       clock,
   input  logic       reset,
   lts_req_if.sink    req_chan,
   lts_rsp_if.source  rsp_chan,
   lts_csr_if.sink    csr_chan
);
   import lts_pkg::*;

   cfg_type      cfg;
   req_item_type req_word;
   rsp_item_type step_result;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_word_ff;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_word_ff;

   logic advance;
   logic req_take;

   // move the held request into the result register when there is room
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   assign req_word.mode                = req_chan.mode;
   assign req_word.airspeed            = req_chan.airspeed;
   assign req_word.flap_angle          = req_chan.flap_angle;
   assign req_word.gear_ratio          = req_chan.gear_ratio;
   assign req_word.height_above_ground = req_chan.height_above_ground;
   assign req_word.throttle_level      = req_chan.throttle_level;
   assign req_word.wheels_on_ground    = req_chan.wheels_on_ground;

   lts_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   lts_seq_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_word_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)             out_valid_in = 1'b1;
      else if (rsp_chan.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) in_word_ff  <= req_word;
      if (advance)  out_word_ff <= step_result;
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.phase              = out_word_ff.phase;
   assign rsp_chan.throttle_down_hold = out_word_ff.throttle_down_hold;
   assign rsp_chan.reverse_hold       = out_word_ff.reverse_hold;
   assign rsp_chan.arm_accepted       = out_word_ff.arm_accepted;
   assign rsp_chan.already_armed      = out_word_ff.already_armed;
   assign rsp_chan.speed_too_high     = out_word_ff.speed_too_high;
   assign rsp_chan.flaps_too_low      = out_word_ff.flaps_too_low;
   assign rsp_chan.gear_not_down      = out_word_ff.gear_not_down;
   assign rsp_chan.height_too_high    = out_word_ff.height_too_high;

   // request side only stalls with both registers full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with a free register");

   // a word moved on is offered on the result side next cycle
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word missing from result register");

   // arm flags are mutually exclusive in any result word
   a_arm_flags: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_word_ff.arm_accepted && out_word_ff.already_armed))
      else $error("arm accepted and already armed together");

endmodule

FILE: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lts_pkg::*;

   // run limits
   localparam int unsigned CYCLE_LIMIT     = 400_000;
   localparam int unsigned SETTLE_CYCLES   = 6;    // two-stage pipe, with margin
   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam int unsigned RANDOM_WORDS    = 280;
   localparam int unsigned STEADY_WORDS    = 60;

   // mode code with no meaning; the block must leave its state alone
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE         = 3'd0,
      PH_START        = 3'd1,
      PH_THR_DOWN     = 3'd2,
      PH_WAIT_IDLE    = 3'd3,
      PH_WAIT_TOUCH   = 3'd4,
      PH_REVERSE      = 3'd5,
      PH_WAIT_REV_END = 3'd6
   } phase_type;

   logic clock;
   logic reset;

   lts_req_if req_if ();
   lts_rsp_if rsp_if ();
   lts_csr_if csr_if ();

   landing_thrust_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // ---------------------------------------------------------------------
   // Shadow of the sequencer: limits as last written, phase and the holds
   // ---------------------------------------------------------------------
   cfg_type            limits;
   logic [PHASE_W-1:0] seq_phase;
   logic               stop_latched;
   logic               thr_hold;
   logic               rev_hold;

   // predicted result words, oldest first
   rsp_item_type landing_results[$];

   int unsigned words_sent;
   int unsigned words_checked;
   int unsigned fail_count;

   bit   tx_idle_en;   // sender may insert gaps
   bit   rx_idle_en;   // receiver may drop ready
   bit   long_stall;   // long receiver hold-off in progress
   event hold_off_kick;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Error reporting
   // ---------------------------------------------------------------------
   task automatic report_error(string msg);
      $display("%0d ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic cmp_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want)
         report_error($sformatf("word %0d %s got %0h want %0h",
                                words_checked, name, got, want));
   endtask

   task automatic check_word(rsp_item_type want);
      cmp_field("phase",              rsp_if.phase,              want.phase);
      cmp_field("throttle_down_hold", rsp_if.throttle_down_hold, want.throttle_down_hold);
      cmp_field("reverse_hold",       rsp_if.reverse_hold,       want.reverse_hold);
      cmp_field("arm_accepted",       rsp_if.arm_accepted,       want.arm_accepted);
      cmp_field("already_armed",      rsp_if.already_armed,      want.already_armed);
      cmp_field("speed_too_high",     rsp_if.speed_too_high,     want.speed_too_high);
      cmp_field("flaps_too_low",      rsp_if.flaps_too_low,      want.flaps_too_low);
      cmp_field("gear_not_down",      rsp_if.gear_not_down,      want.gear_not_down);
      cmp_field("height_too_high",    rsp_if.height_too_high,    want.height_too_high);
   endtask

   // ---------------------------------------------------------------------
   // Predictor: one request word in, one result word out
   // ---------------------------------------------------------------------
   function automatic void abandon_sequence();
      thr_hold     = 1'b0;
      rev_hold     = 1'b0;
      stop_latched = 1'b0;
      seq_phase    = PH_IDLE;
   endfunction

   function automatic rsp_item_type landing_step(req_item_type w);
      rsp_item_type r;
      r = '0;
      case (w.mode)
         MODE_TICK: begin
            case (seq_phase)
               PH_IDLE: ;
               PH_START:
                  seq_phase = (w.throttle_level != 0) ? PH_THR_DOWN : PH_WAIT_TOUCH;
               PH_THR_DOWN: begin
                  thr_hold  = 1'b1;
                  seq_phase = PH_WAIT_IDLE;
               end
               PH_WAIT_IDLE: begin
                  if (stop_latched) begin
                     abandon_sequence();
                  end else if (w.throttle_level == 0) begin
                     thr_hold  = 1'b0;
                     seq_phase = PH_WAIT_TOUCH;
                  end
               end
               PH_WAIT_TOUCH: begin
                  if (stop_latched) begin
                     abandon_sequence();
                  end else if (w.wheels_on_ground) begin
                     seq_phase = PH_REVERSE;
                  end
               end
               PH_REVERSE: begin
                  if (w.airspeed > limits.reverse_min_speed) begin
                     rev_hold  = 1'b1;
                     seq_phase = PH_WAIT_REV_END;
                  end else begin
                     seq_phase = PH_IDLE;   // stop, if latched, survives this
                  end
               end
               PH_WAIT_REV_END: begin
                  if (stop_latched) begin
                     abandon_sequence();
                  end else if (w.airspeed <= limits.reverse_min_speed) begin
                     rev_hold  = 1'b0;
                     seq_phase = PH_IDLE;
                  end
               end
               default: abandon_sequence();
            endcase
         end
         MODE_ARM: begin
            if (seq_phase == PH_IDLE) begin
               r.speed_too_high  = w.airspeed > limits.arm_max_airspeed;
               r.flaps_too_low   = w.flap_angle < limits.arm_min_flap;
               r.gear_not_down   = w.gear_ratio != limits.gear_down_value;
               r.height_too_high = $signed(w.height_above_ground) >
                                   $signed(limits.arm_max_height);
               if (!(r.speed_too_high || r.flaps_too_low || r.gear_not_down ||
                     r.height_too_high)) begin
                  stop_latched   = 1'b0;
                  seq_phase      = PH_START;
                  r.arm_accepted = 1'b1;
               end
            end else begin
               r.already_armed = 1'b1;
            end
         end
         MODE_STOP: begin
            if (seq_phase != PH_IDLE)
               stop_latched = 1'b1;
         end
         default: ;   // reserved mode: nothing moves
      endcase
      r.phase              = seq_phase;
      r.throttle_down_hold = thr_hold;
      r.reverse_hold       = rev_hold;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // valid is only ever raised or lowered once per edge: back-to-back words
   // just keep it high and swap the payload
   task automatic send_word(req_item_type w);
      int unsigned gap;
      gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid               <= 1'b1;
      req_if.mode                <= w.mode;
      req_if.airspeed            <= w.airspeed;
      req_if.flap_angle          <= w.flap_angle;
      req_if.gear_ratio          <= w.gear_ratio;
      req_if.height_above_ground <= w.height_above_ground;
      req_if.throttle_level      <= w.throttle_level;
      req_if.wheels_on_ground    <= w.wheels_on_ground;
      do @(posedge clock); while (!req_if.ready);
      landing_results.push_back(landing_step(w));
      words_sent++;
   endtask

   function automatic req_item_type rand_word();
      req_item_type w;
      w.mode                = $urandom_range(0, 3);
      w.airspeed            = $urandom_range(0, 16383);
      w.flap_angle          = $urandom_range(0, 1023);
      w.gear_ratio          = $urandom_range(0, 511);
      w.height_above_ground = $urandom_range(0, 65535);
      w.throttle_level      = $urandom_range(0, 511);
      w.wheels_on_ground    = $urandom_range(0, 1);
      return w;
   endfunction

   // any mode, the sensor fields left random
   task automatic send_mode(logic [MODE_W-1:0] m);
      req_item_type w;
      w      = rand_word();
      w.mode = m;
      send_word(w);
   endtask

   task automatic send_tick(int unsigned spd, int unsigned thr, bit wheels);
      req_item_type w;
      w                  = rand_word();
      w.mode             = MODE_TICK;
      w.airspeed         = spd;
      w.throttle_level   = thr;
      w.wheels_on_ground = wheels;
      send_word(w);
   endtask

   task automatic send_arm(int spd, int flap, int gear, int hgt);
      req_item_type w;
      w                     = rand_word();
      w.mode                = MODE_ARM;
      w.airspeed            = spd;
      w.flap_angle          = flap;
      w.gear_ratio          = gear;
      w.height_above_ground = hgt;
      send_word(w);
   endtask

   // arm request sitting exactly on every limit: must still be taken
   task automatic arm_at_limits();
      send_arm(limits.arm_max_airspeed, limits.arm_min_flap, limits.gear_down_value,
               $signed(limits.arm_max_height));
   endtask

   // arm request anywhere inside the current limits
   task automatic send_good_arm();
      int hi;
      int h;
      hi = $signed(limits.arm_max_height);
      h  = $urandom_range(0, hi + 32768);
      send_arm($urandom_range(0, limits.arm_max_airspeed),
               $urandom_range(limits.arm_min_flap, 1023),
               limits.gear_down_value, h - 32768);
   endtask

   // airspeed mostly hugging the reverse threshold so both exits are taken
   function automatic int unsigned flight_speed();
      int c;
      int j;
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 16383);
      j = $urandom_range(0, 4);
      c = limits.reverse_min_speed + j - 2;
      if (c < 0)
         c = 0;
      if (c > 16383)
         c = 16383;
      return c;
   endfunction

   // one landing: arm, then mostly ticks with the odd stop, re-arm, reserved
   // word or pure noise thrown in, until the sequence falls back to idle
   task automatic fly_landing(int unsigned max_steps);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         send_good_arm();
      else if (pick < 80)
         arm_at_limits();
      else
         send_mode(MODE_ARM);
      for (int n = 0; n < max_steps && seq_phase != PH_IDLE; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)
            send_mode(MODE_STOP);
         else if (pick < 9)
            send_mode(MODE_ARM);
         else if (pick < 12)
            send_mode(MODE_RESERVED);
         else if (pick < 15)
            send_word(rand_word());
         else
            send_tick(flight_speed(),
                      ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 511),
                      $urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 3) == 0)
         send_mode(MODE_STOP);   // stop while idle
   endtask

   // wait until every predicted word has come back, then let the pipe settle
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (landing_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Configuration side
   // ---------------------------------------------------------------------
   // leaves csr valid high; the caller drops it after its last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_REVERSE_MIN_SPEED: limits.reverse_min_speed = data[SPEED_W-1:0];
         CSR_ARM_MAX_AIRSPEED:  limits.arm_max_airspeed  = data[SPEED_W-1:0];
         CSR_ARM_MIN_FLAP:      limits.arm_min_flap      = data[FLAP_W-1:0];
         CSR_ARM_MAX_HEIGHT:    limits.arm_max_height    = data[HEIGHT_W-1:0];
         CSR_GEAR_DOWN_VALUE:   limits.gear_down_value   = data[RATIO_W-1:0];
         default: ;             // unmapped: dropped
      endcase
   endtask

   // junk above the register width must be ignored
   function automatic logic [CSR_DATA_W-1:0] pad_bits(logic [CSR_DATA_W-1:0] v, int w);
      logic [CSR_DATA_W-1:0] m;
      logic [CSR_DATA_W-1:0] r;
      m = 16'hFFFF >> (CSR_DATA_W - w);
      r = $urandom_range(0, 65535);
      return (r & ~m) | (v & m);
   endfunction

   task automatic program_limits(cfg_type c);
      drain_results();
      write_reg(CSR_REVERSE_MIN_SPEED, pad_bits(c.reverse_min_speed, SPEED_W));
      write_reg(CSR_ARM_MAX_AIRSPEED,  pad_bits(c.arm_max_airspeed, SPEED_W));
      write_reg(CSR_ARM_MIN_FLAP,      pad_bits(c.arm_min_flap, FLAP_W));
      write_reg(CSR_ARM_MAX_HEIGHT,    c.arm_max_height);
      write_reg(CSR_GEAR_DOWN_VALUE,   pad_bits(c.gear_down_value, RATIO_W));
      for (int i = CSR_GEAR_DOWN_VALUE + 1; i < 2 ** CSR_IDX_W; i++)
         write_reg(i, $urandom_range(0, 65535));
      csr_if.valid <= 1'b0;
   endtask

   // mostly plausible limits, now and then anything the field holds; the height limit is always anything
   function automatic cfg_type rand_limits();
      cfg_type c;
      c.reverse_min_speed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                          : $urandom_range(400, 2000);
      c.arm_max_airspeed  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                          : $urandom_range(1500, 4000);
      c.arm_min_flap      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, 400);
      c.arm_max_height    = $urandom_range(0, 65535);
      c.gear_down_value   = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(0, 511);
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // refusals at reset limits: all at once, then each one alone, one step over
   task automatic test_arm_limits();
      send_arm(16383, 0, 0, 32767);
      send_arm(RST_ARM_MAX_AIRSPEED + 1, RST_ARM_MIN_FLAP, RST_GEAR_DOWN_VALUE,
               RST_ARM_MAX_HEIGHT);
      send_arm(RST_ARM_MAX_AIRSPEED, RST_ARM_MIN_FLAP - 1, RST_GEAR_DOWN_VALUE,
               RST_ARM_MAX_HEIGHT);
      send_arm(RST_ARM_MAX_AIRSPEED, RST_ARM_MIN_FLAP, 511, RST_ARM_MAX_HEIGHT);
      send_arm(RST_ARM_MAX_AIRSPEED, RST_ARM_MIN_FLAP, RST_GEAR_DOWN_VALUE,
               RST_ARM_MAX_HEIGHT + 1);
   endtask

   // walk every phase and every way out of it
   task automatic test_phase_walk();
      // far side of every limit; then re-arm, reserved word, stop in start
      send_arm(0, 1023, RST_GEAR_DOWN_VALUE, -32768);
      send_mode(MODE_ARM);
      send_mode(MODE_RESERVED);
      send_mode(MODE_STOP);
      send_tick(1000, 256, 1'b0);                        // throttle down
      send_tick(1000, 256, 1'b0);                        // hold, wait idle
      send_tick(1000, 0, 1'b1);                          // latched stop wins
      send_mode(MODE_STOP);                              // idle: ignored
      // clean landing with reverse
      arm_at_limits();
      send_tick(0, 0, 1'b0);                             // straight to touchdown
      send_tick(0, 0, 1'b1);
      send_tick(RST_REVERSE_MIN_SPEED + 1, 0, 1'b0);     // reverse held
      send_tick(RST_REVERSE_MIN_SPEED, 0, 1'b1);         // reverse ends
      // stop raised in reverse phase outlives the drop to idle
      arm_at_limits();
      send_tick(0, 0, 1'b1);
      send_tick(0, 0, 1'b1);
      send_mode(MODE_STOP);
      send_tick(0, 0, 1'b0);
      // a fresh arm must clear it: touchdown wait holds instead of aborting
      arm_at_limits();
      send_tick(0, 0, 1'b0);
      send_tick(0, 0, 1'b0);
      // stop while reverse is held
      send_tick(0, 0, 1'b1);
      send_tick(16383, 0, 1'b0);
      send_mode(MODE_STOP);
      send_tick(16383, 0, 1'b0);
   endtask

   // all-low, all-high and a mixed set of limits, a few landings each
   task automatic test_config_extremes();
      cfg_type c;
      c                = '0;
      c.arm_max_height = 16'h8000;
      program_limits(c);
      repeat (3) fly_landing(30);
      c                = '1;
      c.arm_max_height = 16'h7FFF;
      program_limits(c);
      repeat (3) fly_landing(30);
      c.reverse_min_speed = '0;
      c.arm_min_flap      = '0;
      c.gear_down_value   = 9'd256;
      program_limits(c);
      repeat (3) fly_landing(30);
   endtask

   // receiver goes quiet while words keep coming: the pipe fills and the
   // request side has to stall
   task automatic test_backpressure();
      int unsigned goal;
      tx_idle_en = 1'b0;
      -> hold_off_kick;
      goal = words_sent + 40;
      while (words_sent < goal)
         fly_landing(20);
      tx_idle_en = 1'b1;
   endtask

   task automatic test_random_flights();
      int unsigned goal;
      int unsigned next_cfg;
      goal = words_sent + RANDOM_WORDS;
      while (words_sent < goal) begin
         program_limits(rand_limits());
         tx_idle_en = $urandom_range(0, 3) != 0;
         rx_idle_en = $urandom_range(0, 3) != 0;
         next_cfg   = words_sent + 70;
         while (words_sent < next_cfg && words_sent < goal)
            fly_landing(40);
      end
   endtask

   // closing stretch at full rate, no gaps either side
   task automatic test_steady_stream();
      int unsigned goal;
      program_limits(rand_limits());
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      goal       = words_sent + STEADY_WORDS;
      while (words_sent < goal)
         fly_landing(40);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                      <= 1'b1;
      req_if.valid               <= 1'b0;
      req_if.mode                <= '0;
      req_if.airspeed            <= '0;
      req_if.flap_angle          <= '0;
      req_if.gear_ratio          <= '0;
      req_if.height_above_ground <= '0;
      req_if.throttle_level      <= '0;
      req_if.wheels_on_ground    <= 1'b0;
      csr_if.valid               <= 1'b0;
      csr_if.index               <= '0;
      csr_if.data                <= '0;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      // shadow state as the block comes out of reset
      limits.reverse_min_speed = RST_REVERSE_MIN_SPEED;
      limits.arm_max_airspeed  = RST_ARM_MAX_AIRSPEED;
      limits.arm_min_flap      = RST_ARM_MIN_FLAP;
      limits.arm_max_height    = RST_ARM_MAX_HEIGHT;
      limits.gear_down_value   = RST_GEAR_DOWN_VALUE;
      seq_phase    = PH_IDLE;
      stop_latched = 1'b0;
      thr_hold     = 1'b0;
      rev_hold     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_arm_limits();
      test_phase_walk();
      test_config_extremes();
      test_backpressure();
      test_random_flights();
      test_steady_stream();

      drain_results();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: check each word taken, then decide next cycle's ready
   // ---------------------------------------------------------------------
   initial begin
      int unsigned rx_gap;
      rx_gap = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (landing_results.size() == 0)
               report_error($sformatf("word %0d arrived with nothing expected",
                                      words_checked));
            else
               check_word(landing_results.pop_front());
            words_checked++;
         end
         if (reset || long_stall) begin
            rsp_if.ready <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap--;
            rsp_if.ready <= 1'b0;
         end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 13);   // burst of ready held low
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off, counted here so the sender never waits on it
   initial begin
      long_stall <= 1'b0;
      forever begin
         @(hold_off_kick);
         long_stall <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         long_stall <= 1'b0;
      end
   end

   // watchdog
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
src/lts_pkg.sv
src/lts_req_if.sv
src/lts_rsp_if.sv
src/lts_csr_if.sv
src/lts_csr_regs.sv
src/lts_seq_fsm.sv
src/landing_thrust_sequencer.sv
dv/tb_top.sv
